>>> hdl/acrt_pkg.sv
// Shared types, tables and AES/CMAC helper functions for the rolling code tag block.
`default_nettype none

package acrt_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned CntW      = 4;
    localparam int unsigned CfgIdxW   = 8;

    typedef enum logic [1:0] {
        CFG_KEY_WORD0 = 2'd0,
        CFG_KEY_WORD1 = 2'd1,
        CFG_KEY_WORD2 = 2'd2,
        CFG_KEY_WORD3 = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KS_LOAD,
        KS_RUN,
        KS_DONE
    } ks_state_t;

    typedef struct packed {
        logic         ready;
        logic [127:0] k2;
    } key_status_t;

    localparam logic [7:0] RB_CONST  = 8'h87;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] RCON_INIT = 8'h01;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // GF(2^8) multiply by x
    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i sits at [127-8i -: 8]
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
        return s[127 - 8 * i -: 8];
    endfunction

    // SubBytes + ShiftRows + optional MixColumns + AddRoundKey
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[c * 4 + j] = SBOX[get_byte(s, ((c + j) % 4) * 4 + j)];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0  = t[c * 4];
                a1  = t[c * 4 + 1];
                a2  = t[c * 4 + 2];
                a3  = t[c * 4 + 3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[c * 4]     = a0 ^ all ^ xtime(a0 ^ a1);
                t[c * 4 + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[c * 4 + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[c * 4 + 3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = t[i];
        end
        return r ^ rk;
    endfunction

    // next AES-128 round key
    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // CMAC doubling: shift left, fold Rb into the last byte
    function automatic logic [127:0] cmac_dbl(input logic [127:0] b);
        logic [127:0] v;
        v = {b[126:0], 1'b0};
        v[7:0] = v[7:0] ^ (b[127] ? RB_CONST : 8'h00);
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/acrt_key_setup.sv
// Key registers, iterative key expansion and CMAC subkey K2 derivation.
`default_nettype none

module acrt_key_setup (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [acrt_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [31:0]                   cfg_data,
    output logic [acrt_pkg::NumRounds:0][127:0] round_keys,
    output acrt_pkg::key_status_t              status
);

    logic [31:0]                 key_reg [4];
    acrt_pkg::ks_state_t         state_reg, state_next;
    logic [acrt_pkg::CntW-1:0]   cnt_reg, cnt_next;
    logic [7:0]                  rcon_reg, rcon_next;
    logic [127:0]                cur_reg, cur_next;
    logic [127:0]                l_reg, l_next;
    logic [127:0]                rk_reg [acrt_pkg::NumRounds + 1];
    logic [127:0]                key_full;
    logic [127:0]                step_key;
    logic                        last_step;

    assign key_full  = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
    assign step_key  = acrt_pkg::key_next(cur_reg, rcon_reg);
    assign last_step = (cnt_reg == acrt_pkg::CntW'(acrt_pkg::NumRounds));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= 32'h0;
            end
        end
        else if (cfg_we && cfg_index < acrt_pkg::CfgIdxW'(4)) begin
            key_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= acrt_pkg::KS_LOAD;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        cnt_reg  <= cnt_next;
        rcon_reg <= rcon_next;
        cur_reg  <= cur_next;
        l_reg    <= l_next;
        if (state_reg == acrt_pkg::KS_LOAD) begin
            rk_reg[0] <= key_full;
        end
        for (int r = 1; r <= acrt_pkg::NumRounds; r++) begin
            if (state_reg == acrt_pkg::KS_RUN && cnt_reg == acrt_pkg::CntW'(r)) begin
                rk_reg[r] <= step_key;
            end
        end
    end

    // round keys and the zero-block encryption advance together, one round a cycle
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rcon_next  = rcon_reg;
        cur_next   = cur_reg;
        l_next     = l_reg;
        unique case (state_reg)
            acrt_pkg::KS_LOAD: begin
                cnt_next   = acrt_pkg::CntW'(1);
                rcon_next  = acrt_pkg::RCON_INIT;
                cur_next   = key_full;
                l_next     = key_full;
                state_next = acrt_pkg::KS_RUN;
            end
            acrt_pkg::KS_RUN: begin
                cnt_next  = cnt_reg + acrt_pkg::CntW'(1);
                rcon_next = acrt_pkg::xtime(rcon_reg);
                cur_next  = step_key;
                l_next    = acrt_pkg::aes_round(l_reg, step_key, last_step);
                if (last_step) begin
                    state_next = acrt_pkg::KS_DONE;
                end
            end
            acrt_pkg::KS_DONE: begin
                state_next = acrt_pkg::KS_DONE;
            end
            default: begin
                state_next = acrt_pkg::KS_LOAD;
            end
        endcase
        if (cfg_we) begin
            state_next = acrt_pkg::KS_LOAD;
        end
    end

    always_comb begin
        for (int r = 0; r <= acrt_pkg::NumRounds; r++) begin
            round_keys[r] = rk_reg[r];
        end
    end

    assign status.ready = (state_reg == acrt_pkg::KS_DONE);
    assign status.k2    = acrt_pkg::cmac_dbl(acrt_pkg::cmac_dbl(l_reg));

endmodule

`default_nettype wire

>>> hdl/aes_cmac_rolling_code_tag.sv
// Top level: AES-128 CMAC tag over a rolling counter and command byte, fully pipelined.
//
//  channel | signals                                   | dir | word
//  --------+-------------------------------------------+-----+---------------------------
//  in      | in_valid/in_ready, counter_value, command_byte | in | one message to tag
//  out     | out_valid/out_ready, mac_tag               | out | 32-bit tag per message
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | in  | one key register write
//
// One word enters per cycle while in_ready is high and the pipe advances. The pipe
// is an input whitening stage plus one stage per AES round, the last stage being
// the output register. After reset and after any key write, the key setup unit
// expands the key and derives K2 (one round per cycle); in_ready stays low meanwhile.
// The whole pipe advances when the output stage is empty or taken; otherwise all
// stages hold, so nothing is lost or repeated.
`default_nettype none

module aes_cmac_rolling_code_tag (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [31:0]                  counter_value,
    input  wire logic [7:0]                   command_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [31:0]                       mac_tag,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [acrt_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [31:0]                  cfg_data
);

    localparam int unsigned Last = acrt_pkg::NumRounds;

    logic [acrt_pkg::NumRounds:0][127:0] round_keys;
    acrt_pkg::key_status_t               ks;
    logic                                cfg_we;
    logic                                adv;
    logic                                in_acc;
    logic [127:0]                        msg;
    logic [127:0]                        st_reg [Last + 1];
    logic [Last:0]                       v_reg;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    acrt_key_setup u_key_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .round_keys (round_keys),
        .status     (ks)
    );

    // global advance: output stage empty or being drained
    assign adv      = !v_reg[Last] || out_ready;
    assign in_ready = ks.ready && adv;
    assign in_acc   = in_valid && in_ready;

    // padded block: counter little-endian, command, 0x80 pad, zeros
    assign msg = {counter_value[7:0], counter_value[15:8], counter_value[23:16],
                  counter_value[31:24], command_byte, acrt_pkg::PAD_BYTE, 80'h0};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (adv) begin
            v_reg <= {v_reg[Last-1:0], in_acc};
        end
    end

    // stage 0: XOR with K2 and the first round key; stages 1..10: AES rounds
    always_ff @(posedge clk) begin
        if (adv) begin
            st_reg[0] <= msg ^ ks.k2 ^ round_keys[0];
            for (int r = 1; r <= Last; r++) begin
                st_reg[r] <= acrt_pkg::aes_round(st_reg[r-1], round_keys[r], r == Last);
            end
        end
    end

    assign out_valid = v_reg[Last];
    // first four ciphertext bytes as a little-endian word
    assign mac_tag   = {st_reg[Last][103:96], st_reg[Last][111:104],
                        st_reg[Last][119:112], st_reg[Last][127:120]};

`ifndef SYNTHESIS
    a_no_accept_during_setup: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ks.ready)
        else $error("item accepted while key setup busy");

    a_cfg_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("in_ready high right after key write");

    a_out_from_prev_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v_reg[Last]) |-> $past(v_reg[Last-1]))
        else $error("output valid without a word in the previous stage");
`endif

endmodule

`default_nettype wire

>>> verif/aes_cmac_rolling_code_tag_tb.sv
// Testbench for the rolling code CMAC tag block: keyed phases, directed and random words.
`default_nettype none

module aes_cmac_rolling_code_tag_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] cnt;
        logic [7:0]  cmd;
    } msg_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] counter_value;
    logic [7:0]  command_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] mac_tag;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [acrt_pkg::CfgIdxW-1:0] cfg_index;
    logic [31:0] cfg_data;

    aes_cmac_rolling_code_tag dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .counter_value (counter_value),
        .command_byte  (command_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mac_tag       (mac_tag),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ---------------------------------------------------------------
    // Tag predictor: own copy of the key, round key schedule and K2
    // ---------------------------------------------------------------
    logic [31:0]  key_regs [4];
    logic [7:0]   round_keys [176];
    logic [127:0] subkey_k2;

    msg_t         msg_q [$];   // words waiting to be offered
    logic [31:0]  tag_q [$];   // tags owed by the block, oldest first
    int           mismatches;
    int           words_taken;
    bit           in_took;

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte 0 of a block sits in bits [127:120]
    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
        logic [7:0]   st [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, sum;
        logic [127:0] ct;
        for (int i = 0; i < 16; i++)
            st[i] = pt[127 - 8 * i -: 8] ^ round_keys[i];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[c * 4 + r] = acrt_pkg::SBOX[st[((c + r) % 4) * 4 + r]];
            if (rnd != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0  = t[c * 4];
                    a1  = t[c * 4 + 1];
                    a2  = t[c * 4 + 2];
                    a3  = t[c * 4 + 3];
                    sum = a0 ^ a1 ^ a2 ^ a3;
                    t[c * 4]     = a0 ^ sum ^ gf_dbl(a0 ^ a1);
                    t[c * 4 + 1] = a1 ^ sum ^ gf_dbl(a1 ^ a2);
                    t[c * 4 + 2] = a2 ^ sum ^ gf_dbl(a2 ^ a3);
                    t[c * 4 + 3] = a3 ^ sum ^ gf_dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = t[i] ^ round_keys[rnd * 16 + i];
        end
        for (int i = 0; i < 16; i++)
            ct[127 - 8 * i -: 8] = st[i];
        return ct;
    endfunction

    // CMAC doubling: Rb folds into the last byte only
    function automatic logic [127:0] block_dbl(input logic [127:0] b);
        return {b[126:0], 1'b0} ^ (b[127] ? 128'h87 : 128'h0);
    endfunction

    // rebuild the key schedule and K2 whenever a key word changes
    task automatic rekey();
        logic [7:0] w [4];
        logic [7:0] f;
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
            round_keys[i] = key_regs[i / 4][31 - 8 * (i % 4) -: 8];
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++)
                w[j] = round_keys[i - 4 + j];
            if (i % 16 == 0) begin
                f    = w[0];
                w[0] = acrt_pkg::SBOX[w[1]] ^ rc;
                w[1] = acrt_pkg::SBOX[w[2]];
                w[2] = acrt_pkg::SBOX[w[3]];
                w[3] = acrt_pkg::SBOX[f];
                rc   = gf_dbl(rc);
            end
            for (int j = 0; j < 4; j++)
                round_keys[i + j] = round_keys[i - 16 + j] ^ w[j];
        end
        subkey_k2 = block_dbl(block_dbl(aes_encrypt(128'h0)));
    endtask

    function automatic logic [31:0] rolling_tag(input logic [31:0] cnt, input logic [7:0] cmd);
        logic [127:0] blk;
        logic [127:0] ct;
        blk = {cnt[7:0], cnt[15:8], cnt[23:16], cnt[31:24], cmd, 8'h80, 80'h0};
        ct  = aes_encrypt(blk ^ subkey_k2);
        // first four output bytes, little-endian
        return {ct[103:96], ct[111:104], ct[119:112], ct[127:120]};
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset
    // ---------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Monitor: takes both handshakes at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                tag_q.push_back(rolling_tag(counter_value, command_byte));
                in_took = 1'b1;
                words_taken++;
            end
            if (out_valid && out_ready) begin
                if (tag_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected tag word %h", mac_tag);
                end else begin
                    if (mac_tag !== tag_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mac_tag mismatch: expected %h got %h", tag_q[0], mac_tag);
                    end
                    void'(tag_q.pop_front());
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver: bursts of random length, random gaps; gap 0 is common
    // ---------------------------------------------------------------
    int   burst_left;
    int   gap_left;
    msg_t cur;

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (msg_q.size() > 0) begin
                cur = msg_q.pop_front();
                counter_value <= cur.cnt;
                command_byte  <= cur.cmd;
                in_valid      <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
        in_took = 1'b0;
    end

    // ---------------------------------------------------------------
    // Receiver: stall density redrawn at random; one long
    // hold-off after 300 words so the pipe fills and in_ready drops
    // ---------------------------------------------------------------
    int rx_cycle;
    int rx_pct;
    int hold_left;
    bit hold_done;

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_pct = 0;
                    1: rx_pct = 25;
                    2: rx_pct = 60;
                    default: rx_pct = 90;
                endcase
            end
            if (!hold_done && words_taken >= 300) begin
                hold_done = 1'b1;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: key phases, directed words, then random words
    // ---------------------------------------------------------------
    task automatic cfg_write(input logic [acrt_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // out-of-range indexes are dropped by the block
        if (idx < 4) begin
            key_regs[idx] = val;
            rekey();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_key(input logic [127:0] k);
        cfg_write(acrt_pkg::CFG_KEY_WORD0, k[127:96]);
        cfg_write(acrt_pkg::CFG_KEY_WORD1, k[95:64]);
        cfg_write(acrt_pkg::CFG_KEY_WORD2, k[63:32]);
        cfg_write(acrt_pkg::CFG_KEY_WORD3, k[31:0]);
        cfg_write(acrt_pkg::CfgIdxW'($urandom_range(4, 255)), $urandom);
    endtask

    task automatic queue_msg(input logic [31:0] cnt, input logic [7:0] cmd);
        msg_t m;
        m.cnt = cnt;
        m.cmd = cmd;
        msg_q.push_back(m);
    endtask

    // sender pause: wait until every owed tag is back, plus pipe latency
    task automatic drain();
        while (msg_q.size() != 0 || in_valid || tag_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial begin
        logic [127:0] key;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        counter_value = '0;
        command_byte  = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatches    = 0;
        words_taken   = 0;
        burst_left    = 0;
        gap_left      = 0;
        rx_pct        = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        for (int i = 0; i < 4; i++)
            key_regs[i] = '0;
        rekey();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key (all zero): field extremes and alternating patterns
        queue_msg(32'h0000_0000, 8'h00);
        queue_msg(32'hffff_ffff, 8'hff);
        queue_msg(32'h5555_5555, 8'haa);
        queue_msg(32'haaaa_aaaa, 8'h55);
        queue_msg(32'h0000_0001, 8'h80);
        queue_msg(32'h8000_0000, 8'h01);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: key = '1;
                1: key = 128'h2b7e1516_28aed2a6_abf71588_09cf4f3c;
                2: key = '0;
                default: key = {$urandom, $urandom, $urandom, $urandom};
            endcase
            load_key(key);
            if (ph < 2) begin
                queue_msg(32'h0000_0000, 8'h00);
                queue_msg(32'hffff_ffff, 8'hff);
                queue_msg(32'h1234_5678, 8'h3c);
            end
            for (int n = 0; n < 340; n++)
                queue_msg($urandom, 8'($urandom_range(0, 255)));
            drain();
        end

        if (mismatches == 0)
            $display("aes_cmac_rolling_code_tag_tb OK");
        else
            $display("aes_cmac_rolling_code_tag_tb NOT OK");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("aes_cmac_rolling_code_tag_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
